FILE: sv/erpg_pkg.sv
// ----------------------------------------------------------------------------
// erpg_pkg
// Shared types and constants for the Euclidean rhythm pattern generator.
// ----------------------------------------------------------------------------
package erpg_pkg;

  // sizes and limits
  localparam int unsigned MaxStepsDef = 64;
  localparam int unsigned TracksDef   = 8;
  localparam int unsigned CountW      = 7;
  localparam int unsigned TrackW      = 3;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned VelW        = 7;

  // velocities
  localparam logic [VelW-1:0] VelFirst = 7'd127;
  localparam logic [VelW-1:0] VelOther = 7'd85;
  localparam logic [VelW-1:0] VelRest  = 7'd0;

  // register map (byte addresses)
  localparam int unsigned     AddrW           = 1;
  localparam logic [AddrW-1:0] RegAutoDownbeat = 1'b0;

  // request word
  typedef struct packed {
    logic [TrackW-1:0] track;
    logic [CountW-1:0] step_count;
    logic [CountW-1:0] hit_count;
    logic [CountW-1:0] rotation;
  } req_t;

  // result word
  typedef struct packed {
    logic [TrackW-1:0] track_out;
    logic [IndexW-1:0] step_index;
    logic [VelW-1:0]   velocity;
    logic              last;
  } res_t;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StSeek,
    StAdv,
    StEmit
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mod_sub;
    logic adv_load;
    logic step_bucket;
    logic cnt_dec;
    logic emit_start;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_ok;
    logic r_ge_n;
    logic seek_en;
    logic hit;
    logic cnt_zero;
    logic last_step;
  } ctrl_sts_t;

endpackage

FILE: sv/erpg_ctrl.sv
// ----------------------------------------------------------------------------
// erpg_ctrl
// Sequencer: rotation reduction, downbeat search, phase advance, step emission.
// ----------------------------------------------------------------------------
module erpg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  erpg_pkg::ctrl_sts_t   sts_i,
  output erpg_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o
);

  erpg_pkg::state_e st_q, st_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= erpg_pkg::StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      erpg_pkg::StIdle: begin
        if (start_i && sts_i.req_ok) st_d = erpg_pkg::StMod;
      end
      erpg_pkg::StMod: begin
        if (!sts_i.r_ge_n) begin
          st_d = sts_i.seek_en ? erpg_pkg::StSeek : erpg_pkg::StAdv;
        end
      end
      erpg_pkg::StSeek: begin
        if (sts_i.hit) st_d = erpg_pkg::StAdv;
      end
      erpg_pkg::StAdv: begin
        if (sts_i.cnt_zero) st_d = erpg_pkg::StEmit;
      end
      erpg_pkg::StEmit: begin
        if (sts_i.last_step) st_d = erpg_pkg::StIdle;
      end
      default: st_d = erpg_pkg::StIdle;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    case (st_q)
      erpg_pkg::StIdle: begin
        cmd_o.load = start_i;
      end
      erpg_pkg::StMod: begin
        if (sts_i.r_ge_n) begin
          cmd_o.mod_sub = 1'b1;
        end else if (!sts_i.seek_en) begin
          cmd_o.adv_load = 1'b1;
        end
      end
      erpg_pkg::StSeek: begin
        if (sts_i.hit) begin
          cmd_o.adv_load = 1'b1;
        end else begin
          cmd_o.step_bucket = 1'b1;
        end
      end
      erpg_pkg::StAdv: begin
        if (sts_i.cnt_zero) begin
          cmd_o.emit_start = 1'b1;
        end else begin
          cmd_o.step_bucket = 1'b1;
          cmd_o.cnt_dec     = 1'b1;
        end
      end
      erpg_pkg::StEmit: begin
        cmd_o.emit        = 1'b1;
        cmd_o.step_bucket = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (st_q != erpg_pkg::StIdle);

endmodule

FILE: sv/erpg_dp.sv
// ----------------------------------------------------------------------------
// erpg_dp
// Datapath: request registers, Bresenham bucket, counters and result register.
// ----------------------------------------------------------------------------
module erpg_dp #(
  parameter int unsigned MAX_STEPS = erpg_pkg::MaxStepsDef,
  parameter int unsigned TRACKS    = erpg_pkg::TracksDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  erpg_pkg::req_t        req_i,
  input  logic                  auto_downbeat_i,
  input  erpg_pkg::ctrl_cmd_t   cmd_i,
  output erpg_pkg::ctrl_sts_t   sts_o,
  output erpg_pkg::res_t        res_o,
  output logic                  res_valid_o
);

  localparam int unsigned CW = erpg_pkg::CountW;
  localparam logic [CW-1:0] MaxN = CW'(MAX_STEPS);
  localparam logic [erpg_pkg::TrackW:0] TrackLim = (erpg_pkg::TrackW + 1)'(TRACKS);

  logic [CW-1:0]                n_q, h_q, r_q, bucket_q, cnt_q;
  logic [CW-1:0]                n_d, h_d, r_d, bucket_d, cnt_d;
  logic [erpg_pkg::TrackW-1:0]  trk_q, trk_d;
  logic [erpg_pkg::IndexW-1:0]  idx_q, idx_d;
  logic                         first_seen_q, first_seen_d;
  erpg_pkg::res_t               res_q, res_d;
  logic                         res_valid_q, res_valid_d;

  logic [CW-1:0] n_sat;
  logic [CW:0]   bsum;
  logic          hit;
  logic          all_hits;

  // saturate requested length
  assign n_sat = (req_i.step_count > MaxN) ? MaxN : req_i.step_count;

  // bucket sum and hit decision
  assign bsum     = {1'b0, bucket_q} + {1'b0, h_q};
  assign all_hits = (h_q >= n_q);
  assign hit      = all_hits || (bsum >= {1'b0, n_q});

  // status
  always_comb begin
    sts_o.req_ok    = ({1'b0, req_i.track} < TrackLim) && (req_i.step_count != '0);
    sts_o.r_ge_n    = (r_q >= n_q);
    sts_o.seek_en   = auto_downbeat_i && (h_q != '0) && !all_hits;
    sts_o.hit       = hit;
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.last_step = ({1'b0, idx_q} == (n_q - CW'(1)));
  end

  // next values
  always_comb begin
    n_d          = n_q;
    h_d          = h_q;
    r_d          = r_q;
    trk_d        = trk_q;
    bucket_d     = bucket_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    first_seen_d = first_seen_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;

    if (cmd_i.load) begin
      n_d      = n_sat;
      h_d      = req_i.hit_count;
      r_d      = req_i.rotation;
      trk_d    = req_i.track;
      bucket_d = '0;
    end

    // rotation mod steps by repeated subtraction
    if (cmd_i.mod_sub) r_d = r_q - n_q;

    // steps to walk back by rotation, done as forward steps
    if (cmd_i.adv_load) cnt_d = (r_q == '0) ? '0 : (n_q - r_q);
    if (cmd_i.cnt_dec)  cnt_d = cnt_q - CW'(1);

    // bucket advance, periodic in steps
    if (cmd_i.step_bucket && !all_hits) begin
      bucket_d = (bsum >= {1'b0, n_q}) ? CW'(bsum - {1'b0, n_q}) : CW'(bsum);
    end

    if (cmd_i.emit_start) begin
      idx_d        = '0;
      first_seen_d = 1'b0;
    end

    // result word
    if (cmd_i.emit) begin
      res_valid_d          = 1'b1;
      res_d.track_out      = trk_q;
      res_d.step_index     = idx_q;
      res_d.last           = sts_o.last_step;
      if (hit) begin
        res_d.velocity = first_seen_q ? erpg_pkg::VelOther : erpg_pkg::VelFirst;
        first_seen_d   = 1'b1;
      end else begin
        res_d.velocity = erpg_pkg::VelRest;
      end
      idx_d = idx_q + erpg_pkg::IndexW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q  <= 1'b0;
      n_q          <= '0;
      h_q          <= '0;
      bucket_q     <= '0;
      first_seen_q <= 1'b0;
    end else begin
      res_valid_q  <= res_valid_d;
      n_q          <= n_d;
      h_q          <= h_d;
      bucket_q     <= bucket_d;
      first_seen_q <= first_seen_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    trk_q <= trk_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // bucket stays reduced while a proper pattern is in work
  a_bucket_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q != '0 && h_q < n_q) |-> bucket_q < n_q)
    else $error("bucket out of range");

  // steps of one pattern come out back to back
  a_steps_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.step_index != '0) |-> $past(res_valid_q))
    else $error("gap inside a pattern");

  // final word sits at the pattern end
  a_last_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |-> ({1'b0, res_q.step_index} == n_q - CW'(1)))
    else $error("last flag misplaced");

  // saturated hit count gives only hits
  a_all_hits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && h_q >= n_q) |-> res_q.velocity != erpg_pkg::VelRest)
    else $error("rest in an all-hit pattern");

endmodule

FILE: sv/euclidean_rhythm_pattern_generator.sv
// ----------------------------------------------------------------------------
// euclidean_rhythm_pattern_generator
// Emits a Euclidean step pattern for one track request, one word per step.
//
//   port group      dir  handshake                 payload
//   request         in   start & !busy             req_i (track, counts, rotation)
//   result          out  res_valid_o, one cycle    res_o (track, step, velocity, last)
//   register        in   psel & penable & pwrite   pwdata[0] -> auto_downbeat
//
// While busy, a request runs q = rotation div steps subtract passes (up to 127),
// then with the downbeat search s = rests skipped before the first hit (up to 63),
// then a = phase advance steps (up to 63), then n = steps emitted, one per cycle
// from the bucket adder, each word registered and shown in the following cycle.
// busy stays high from acceptance until the final step word is launched.
// Reset clears the sequencer and sets auto_downbeat to 1.
// The receiver cannot stall; each result word is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module euclidean_rhythm_pattern_generator #(
  parameter int unsigned MAX_STEPS = erpg_pkg::MaxStepsDef,
  parameter int unsigned TRACKS    = erpg_pkg::TracksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  erpg_pkg::req_t               req_i,
  output logic                         res_valid_o,
  output erpg_pkg::res_t               res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [erpg_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  erpg_pkg::ctrl_cmd_t cmd;
  erpg_pkg::ctrl_sts_t sts;
  logic                auto_q, auto_d;
  logic                cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    auto_d = auto_q;
    if (cfg_wr && (paddr == erpg_pkg::RegAutoDownbeat)) auto_d = pwdata[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q <= 1'b1;
    end else begin
      auto_q <= auto_d;
    end
  end

  assign prdata = (paddr == erpg_pkg::RegAutoDownbeat) ? {31'b0, auto_q} : '0;

  // sequencer
  erpg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath
  erpg_dp #(
    .MAX_STEPS (MAX_STEPS),
    .TRACKS    (TRACKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .auto_downbeat_i (auto_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_o           (res_o),
    .res_valid_o     (res_valid_o)
  );

endmodule
